FILE: hw/rtl/isim_pkg.sv
// Package for the interval set insert-and-merge block.
// Holds status codes, register indexes, cell commands and controller states.
// No dependencies; used by isim_cell and interval_set_insert_merge_top.
package isim_pkg;

    localparam int MAX_INTERVALS_DEF = 64;
    localparam int OFFSET_BITS_DEF   = 48;

    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_INVERTED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'b1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_COMPARE,
        CELL_SCAN,
        CELL_MSHIFT,
        CELL_MFIX,
        CELL_INSERT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SCAN,
        ST_DECIDE,
        ST_MSHIFT,
        ST_MFIX,
        ST_INSERT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic dup;
        logic cov;
        logic hit;
    } scan_flags_t;

endpackage

FILE: hw/rtl/isim_cell.sv
// One table slot of the interval set: a stored range plus its compare flags.
// Exchanges contents with its left and right neighbors under a broadcast command.
// Depends on isim_pkg.
module isim_cell #(
    parameter int OFFSET_BITS = isim_pkg::OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  isim_pkg::cell_op_t     op,
    input  logic                   valid,
    input  logic [OFFSET_BITS-1:0] ins_start,
    input  logic [OFFSET_BITS-1:0] ins_end,
    input  logic [OFFSET_BITS-1:0] left_start,
    input  logic [OFFSET_BITS-1:0] left_end,
    input  logic                   left_gelo,
    input  logic [OFFSET_BITS-1:0] right_start,
    input  logic [OFFSET_BITS-1:0] right_end,
    input  isim_pkg::scan_flags_t  right_flags,
    output logic [OFFSET_BITS-1:0] start_o,
    output logic [OFFSET_BITS-1:0] end_o,
    output logic                   gelo_o,
    output isim_pkg::scan_flags_t  flags_o
);
    import isim_pkg::*;

    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] end_reg, end_next;
    logic                   gelo_reg, gelo_next;
    scan_flags_t            flags_reg, flags_next;
    logic                   is_lo;
    logic                   above_lo;

    // Empty slots count as reaching the insert start, so the first slot with
    // gelo set is where the new range lands or where the merge begins.
    assign is_lo    = gelo_reg & ~left_gelo;
    assign above_lo = left_gelo;

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        gelo_next  = gelo_reg;
        flags_next = flags_reg;
        unique case (op)
            CELL_COMPARE: begin
                gelo_next      = ~valid | (end_reg >= ins_start);
                flags_next.dup = valid & (start_reg == ins_start) & (end_reg == ins_end);
                flags_next.cov = valid & (start_reg <= ins_start) & (ins_end <= end_reg);
                flags_next.hit = valid & (end_reg >= ins_start) & (start_reg <= ins_end);
            end
            CELL_SCAN: begin
                flags_next = right_flags;
            end
            CELL_MSHIFT: begin
                if (above_lo) begin
                    start_next = right_start;
                    end_next   = right_end;
                end else if (is_lo) begin
                    end_next = right_end;
                end
            end
            CELL_MFIX: begin
                if (is_lo) begin
                    start_next = (ins_start < start_reg) ? ins_start : start_reg;
                    end_next   = (ins_end > end_reg) ? ins_end : end_reg;
                end
            end
            CELL_INSERT: begin
                if (is_lo) begin
                    start_next = ins_start;
                    end_next   = ins_end;
                end else if (above_lo) begin
                    start_next = left_start;
                    end_next   = left_end;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        end_reg   <= end_next;
        gelo_reg  <= gelo_next;
        flags_reg <= flags_next;
    end

    assign start_o = start_reg;
    assign end_o   = end_reg;
    assign gelo_o  = gelo_reg;
    assign flags_o = flags_reg;

endmodule

FILE: hw/rtl/interval_set_insert_merge_top.sv
// Interval set insert-and-merge: a row of table cells and the sequencer that drives them.
// Depends on isim_pkg and isim_cell.
//
// Usage:
// Input words on s_ carry one half-open range [s_insert_start, s_insert_end).
// Each word gives exactly one result word on m_: status, entry count after the
// insert, and whether a single stored range equals the configured range.
// The configuration port writes range_start (index 0) and range_end (index 1)
// at any edge with cfg_wr_en high; write only while the block is idle.
// One word is in work at a time. A word rejected for start after end or for
// lying outside the range goes straight to its result. Any other word takes
// a compare step, a scan that streams the flags of every cell out of the row,
// a decision step, then one insert step or merge shift steps plus one fix
// step, then an output step; a duplicate, covered, empty or full word goes
// from the decision step straight to the output step.
// The result register is separate, so a finished result waits there while the
// next word is taken; a stalled receiver holds the block only when a second
// result is ready. Reset empties the table and clears both range registers.
module interval_set_insert_merge_top #(
    parameter int MAX_INTERVALS = isim_pkg::MAX_INTERVALS_DEF,
    parameter int OFFSET_BITS   = isim_pkg::OFFSET_BITS_DEF,
    parameter int CNT_W         = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [isim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFFSET_BITS-1:0]          cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [OFFSET_BITS-1:0]          s_insert_start,
    input  logic [OFFSET_BITS-1:0]          s_insert_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [isim_pkg::STATUS_W-1:0]   m_status,
    output logic [CNT_W-1:0]                m_entry_count,
    output logic                            m_range_filled
);
    import isim_pkg::*;

    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_INTERVALS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_INTERVALS);

    logic [OFFSET_BITS-1:0] cell_start [MAX_INTERVALS];
    logic [OFFSET_BITS-1:0] cell_end   [MAX_INTERVALS];
    logic                   cell_gelo  [MAX_INTERVALS];
    scan_flags_t            cell_flags [MAX_INTERVALS];
    cell_op_t               cell_op;

    ctrl_state_t            state_reg, state_next;
    logic [OFFSET_BITS-1:0] s_reg, s_next;
    logic [OFFSET_BITS-1:0] e_reg, e_next;
    logic [OFFSET_BITS-1:0] rs_reg, rs_next;
    logic [OFFSET_BITS-1:0] re_reg, re_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   dup_reg, dup_next;
    logic                   cov_reg, cov_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [CNT_W-1:0]       m_count_reg, m_count_next;
    logic                   m_filled_reg, m_filled_next;

    logic accept;
    logic early_inverted;
    logic early_outside;
    logic out_free;

    assign accept         = s_valid & s_ready;
    assign early_inverted = s_insert_start > s_insert_end;
    assign early_outside  = (s_insert_start < rs_reg) | (s_insert_end > re_reg);
    assign out_free       = ~m_valid_reg | m_ready;

    genvar k;
    generate
        for (k = 0; k < MAX_INTERVALS; k++) begin : g_cell
            logic                   valid_k;
            logic [OFFSET_BITS-1:0] l_start, l_end, r_start, r_end;
            logic                   l_gelo;
            scan_flags_t            r_flags;

            assign valid_k = CNT_W'(k) < count_reg;
            if (k == 0) begin : g_first
                assign l_start = '0;
                assign l_end   = '0;
                assign l_gelo  = 1'b0;
            end else begin : g_mid_l
                assign l_start = cell_start[k-1];
                assign l_end   = cell_end[k-1];
                assign l_gelo  = cell_gelo[k-1];
            end
            if (k == MAX_INTERVALS - 1) begin : g_last
                assign r_start = '0;
                assign r_end   = '0;
                assign r_flags = '0;
            end else begin : g_mid_r
                assign r_start = cell_start[k+1];
                assign r_end   = cell_end[k+1];
                assign r_flags = cell_flags[k+1];
            end

            isim_cell #(
                .OFFSET_BITS(OFFSET_BITS)
            ) u_cell (
                .aclk       (aclk),
                .op         (cell_op),
                .valid      (valid_k),
                .ins_start  (s_reg),
                .ins_end    (e_reg),
                .left_start (l_start),
                .left_end   (l_end),
                .left_gelo  (l_gelo),
                .right_start(r_start),
                .right_end  (r_end),
                .right_flags(r_flags),
                .start_o    (cell_start[k]),
                .end_o      (cell_end[k]),
                .gelo_o     (cell_gelo[k]),
                .flags_o    (cell_flags[k])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (early_inverted || early_outside) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_COMPARE;
                    end
                end
            end
            ST_COMPARE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (dup_reg || cov_reg || (s_reg == e_reg)) begin
                    state_next = ST_DONE;
                end else if (hits_reg > CNT_W'(1)) begin
                    state_next = ST_MSHIFT;
                end else if (hits_reg == CNT_W'(1)) begin
                    state_next = ST_MFIX;
                end else if (count_reg == FULL_CNT) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_MSHIFT: begin
                if (hits_reg == CNT_W'(2)) begin
                    state_next = ST_MFIX;
                end
            end
            ST_MFIX:   state_next = ST_DONE;
            ST_INSERT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready = 1'b0;
        cell_op = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_COMPARE: cell_op = CELL_COMPARE;
            ST_SCAN:    cell_op = CELL_SCAN;
            ST_MSHIFT:  cell_op = CELL_MSHIFT;
            ST_MFIX:    cell_op = CELL_MFIX;
            ST_INSERT:  cell_op = CELL_INSERT;
            default: begin
            end
        endcase
    end

    // Datapath registers of the sequencer and the result word.
    always_comb begin
        s_next        = s_reg;
        e_next        = e_reg;
        rs_next       = rs_reg;
        re_next       = re_reg;
        count_next    = count_reg;
        hits_next     = hits_reg;
        scan_idx_next = scan_idx_reg;
        dup_next      = dup_reg;
        cov_next      = cov_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_filled_next = m_filled_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RANGE_START: rs_next = cfg_wdata;
                CFG_RANGE_END:   re_next = cfg_wdata;
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    s_next        = s_insert_start;
                    e_next        = s_insert_end;
                    scan_idx_next = '0;
                    hits_next     = '0;
                    dup_next      = 1'b0;
                    cov_next      = 1'b0;
                    if (early_inverted) begin
                        status_next = STATUS_INVERTED;
                    end else if (early_outside) begin
                        status_next = STATUS_OUTSIDE;
                    end else begin
                        status_next = STATUS_OK;
                    end
                end
            end
            ST_SCAN: begin
                // The flags stream out of cell 0 while the row shifts them down.
                dup_next      = dup_reg | cell_flags[0].dup;
                cov_next      = cov_reg | cell_flags[0].cov;
                hits_next     = hits_reg + CNT_W'(cell_flags[0].hit);
                scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            ST_DECIDE: begin
                if (dup_reg) begin
                    status_next = STATUS_DUPLICATE;
                end else if (cov_reg || (s_reg == e_reg)) begin
                    status_next = STATUS_OK;
                end else if (hits_reg != '0) begin
                    count_next = count_reg - (hits_reg - CNT_W'(1));
                end else if (count_reg == FULL_CNT) begin
                    status_next = STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_MSHIFT: begin
                hits_next = hits_reg - CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_filled_next = (count_reg == CNT_W'(1)) && (cell_start[0] == rs_reg)
                                    && (cell_end[0] == re_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rs_reg      <= '0;
            re_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rs_reg      <= rs_next;
            re_reg      <= re_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg        <= s_next;
        e_reg        <= e_next;
        hits_reg     <= hits_next;
        scan_idx_reg <= scan_idx_next;
        dup_reg      <= dup_next;
        cov_reg      <= cov_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_filled_reg <= m_filled_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_entry_count  = m_count_reg;
    assign m_range_filled = m_filled_reg;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for interval_set_insert_merge_top.
// A queue-fed driver, a monitor and an in-bench interval table predictor.
// Depends on isim_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import isim_pkg::*;

    localparam int DEPTH = MAX_INTERVALS_DEF;
    localparam int OB    = OFFSET_BITS_DEF;
    localparam logic [OB-1:0] OMAX = {OB{1'b1}};

    typedef struct {
        logic [OB-1:0] lo;
        logic [OB-1:0] hi;
    } span_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [6:0]          count;
        logic                filled;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_START;
    logic [OB-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OB-1:0] s_insert_start = '0;
    logic [OB-1:0] s_insert_end = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [6:0] m_entry_count;
    logic m_range_filled;

    interval_set_insert_merge_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_insert_start(s_insert_start), .s_insert_end(s_insert_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_entry_count(m_entry_count),
        .m_range_filled(m_range_filled)
    );

    // Shadow of the block's table and range registers.
    logic [OB-1:0] tbl_lo [DEPTH];
    logic [OB-1:0] tbl_hi [DEPTH];
    int            tbl_n = 0;
    logic [OB-1:0] win_lo = '0;
    logic [OB-1:0] win_hi = '0;

    span_t    pending_words[$];
    verdict_t expected_verdicts[$];
    int       error_count = 0;
    bit       steady = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic verdict_t finish_verdict(logic [STATUS_W-1:0] st);
        verdict_t v;
        v.status = st;
        v.count  = 7'(tbl_n);
        v.filled = (tbl_n == 1 && tbl_lo[0] == win_lo && tbl_hi[0] == win_hi);
        return v;
    endfunction

    // Applies one insert to the shadow table and returns the result it causes.
    function automatic verdict_t insert_span(logic [OB-1:0] s, logic [OB-1:0] e);
        int first, past, gone;
        logic [OB-1:0] ms, me;
        if (s > e) return finish_verdict(STATUS_INVERTED);
        if (s < win_lo || e > win_hi) return finish_verdict(STATUS_OUTSIDE);
        for (int k = 0; k < tbl_n; k++)
            if (tbl_lo[k] == s && tbl_hi[k] == e) return finish_verdict(STATUS_DUPLICATE);
        if (s == e) return finish_verdict(STATUS_OK);
        for (int k = 0; k < tbl_n; k++)
            if (tbl_lo[k] <= s && e <= tbl_hi[k]) return finish_verdict(STATUS_OK);
        first = tbl_n;
        for (int k = tbl_n - 1; k >= 0; k--)
            if (tbl_hi[k] >= s) first = k;
        past = 0;
        for (int k = 0; k < tbl_n; k++)
            if (tbl_lo[k] <= e) past = k + 1;
        if (first >= past) begin
            if (tbl_n >= DEPTH) return finish_verdict(STATUS_FULL);
            for (int k = tbl_n; k > first; k--) begin
                tbl_lo[k] = tbl_lo[k-1];
                tbl_hi[k] = tbl_hi[k-1];
            end
            tbl_lo[first] = s;
            tbl_hi[first] = e;
            tbl_n++;
            return finish_verdict(STATUS_OK);
        end
        ms = tbl_lo[first] < s ? tbl_lo[first] : s;
        me = tbl_hi[past-1] > e ? tbl_hi[past-1] : e;
        tbl_lo[first] = ms;
        tbl_hi[first] = me;
        gone = past - first - 1;
        for (int k = first + 1; k + gone < tbl_n; k++) begin
            tbl_lo[k] = tbl_lo[k+gone];
            tbl_hi[k] = tbl_hi[k+gone];
        end
        tbl_n -= gone;
        return finish_verdict(STATUS_OK);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [OB-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic bit go_now();
        return steady || ($urandom_range(0, 99) >= 36);
    endfunction

    // Driver: prediction happens at the accepting edge, before the next word loads.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_verdicts.push_back(insert_span(s_insert_start, s_insert_end));
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && go_now()) begin
                    span_t w;
                    w = pending_words.pop_front();
                    s_insert_start <= w.lo;
                    s_insert_end   <= w.hi;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    error_count++;
                end else begin
                    verdict_t v;
                    v = expected_verdicts.pop_front();
                    if (m_status !== v.status)
                        report("status", 32'(m_status), 32'(v.status));
                    if (m_entry_count !== v.count)
                        report("entry_count", 32'(m_entry_count), 32'(v.count));
                    if (m_range_filled !== v.filled)
                        report("range_filled", 32'(m_range_filled), 32'(v.filled));
                end
            end
            m_ready <= go_now();
        end
    end

    task automatic add(logic [OB-1:0] s, logic [OB-1:0] e);
        span_t w;
        w.lo = s;
        w.hi = e;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (140) @(posedge aclk);
    endtask

    task automatic set_window(logic [OB-1:0] lo, logic [OB-1:0] hi);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RANGE_START;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_RANGE_END;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // Random words inside a small window, with some noise around it.
    task automatic add_local(logic [OB-1:0] lo, int width, int maxlen, int n);
        logic [OB-1:0] s, e;
        for (int i = 0; i < n; i++) begin
            s = lo + OB'($urandom_range(0, width));
            e = s + OB'($urandom_range(0, maxlen));
            case ($urandom_range(0, 19))
                0: add(e + OB'(1), s);
                1: add(lo - OB'(1) - OB'($urandom_range(0, 5)), e);
                2: add(s, lo + OB'(width + maxlen + 1) + OB'($urandom_range(0, 5)));
                default: add(s, e);
            endcase
        end
    endtask

    initial begin
        logic [OB-1:0] s, e;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        set_window(48'd1000, 48'd2000);
        add(48'd1100, 48'd1200);
        add(48'd1100, 48'd1200);
        add(48'd1150, 48'd1160);
        add(48'd1300, 48'd1300);
        add(48'd1200, 48'd1300);
        add(48'd900, 48'd1000);
        add(48'd1500, 48'd1400);
        add(48'd1400, 48'd1500);
        add(48'd1600, 48'd1700);
        add(48'd1250, 48'd1650);
        add(48'd0, OMAX);
        add(OMAX, 48'd0);
        add(48'd1000, 48'd2001);
        add(48'd2000, 48'd2000);
        add(48'd1000, 48'd2000);
        add(48'd1000, 48'd2000);

        // Inverted window rejects everything well formed.
        set_window(48'd500, 48'd100);
        add(48'd100, 48'd200);
        add(48'd300, 48'd100);
        add(48'd200, 48'd200);

        // Full offset width, every bit exercised.
        set_window(48'd0, OMAX);
        add(48'd0, OMAX);
        add(48'd0, OMAX);
        for (int i = 0; i < 150; i++) begin
            s = rand48();
            e = rand48();
            if ($urandom_range(0, 3) != 0 && s > e) add(e, s);
            else add(s, e);
        end

        // Isolated points fill the table and then hit the full case.
        set_window(48'd0, 48'd300);
        for (int i = 0; i < 230; i++) begin
            s = OB'(2 * $urandom_range(0, 149));
            add(s, s + OB'($urandom_range(0, 9) == 0 ? 2 : 1));
        end
        add(48'd0, 48'd300);

        steady = 1'b1;
        set_window(48'd1000, 48'd1400);
        add_local(48'd1000, 400, 20, 150);
        steady = 1'b0;

        set_window(48'd0, 48'd0);
        add(48'd0, 48'd0);
        add(48'd0, 48'd1);

        set_window(OMAX - 48'd200, OMAX);
        add_local(OMAX - 48'd200, 190, 10, 300);
        add(OMAX - 48'd200, OMAX);

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/isim_pkg.sv
hw/rtl/isim_cell.sv
hw/rtl/interval_set_insert_merge_top.sv
tb/sv/testbench.sv
